// ----- hw/rtl/mart_pkg.sv -----
package mart_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;

   // widths of the packed stream words
   localparam int REQ_TDATA_W = 168;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 88;

   // operation codes
   localparam logic [2:0] OP_LOOKUP    = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_DEL_MATCH = 3'd2;
   localparam logic [2:0] OP_DEL_INDEX = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   // width used to compare a request index against a slot number
   localparam int SLOT_CMP_W = 8;

   typedef struct packed {
      logic [31:0] match_addr;
      logic [31:0] mask;
      logic [15:0] src_port;
      logic [31:0] remap_addr;
      logic [15:0] dst_port;
      logic [31:0] service_id;
   } entry_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] entry_mask;
      logic [31:0] entry_remap_addr;
      logic [15:0] entry_dst_port;
      logic [31:0] entry_service_id;
      logic [5:0]  index;
   } request_type;

   typedef struct packed {
      logic [31:0] out_addr;
      logic [15:0] out_port;
      logic [31:0] out_service_id;
      logic        hit;
      logic [4:0]  entry_index;
      logic [1:0]  status;
   } result_type;

   // what travels from one cell to the next
   typedef struct packed {
      logic        valid;
      logic        done;
      request_type req;
      result_type  res;
   } token_type;

endpackage

// ----- hw/rtl/mart_cell.sv -----
module mart_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mart_pkg::token_type tok_up,
   output mart_pkg::token_type tok_down
);
   import mart_pkg::*;

   token_type tok_ff;
   token_type tok_in;
   entry_type entry_ff;
   entry_type entry_in;

   logic port_ok;
   logic addr_ok;
   logic all_eq;
   logic slot_sel;

   always_comb begin
      port_ok = (entry_ff.src_port == 16'd0) || (tok_up.req.port == 16'd0) ||
                (entry_ff.src_port == tok_up.req.port);
      addr_ok = entry_ff.match_addr == (tok_up.req.addr & entry_ff.mask);
      all_eq  = (entry_ff.match_addr == tok_up.req.addr) &&
                (entry_ff.mask == tok_up.req.entry_mask) &&
                (entry_ff.src_port == tok_up.req.port) &&
                (entry_ff.remap_addr == tok_up.req.entry_remap_addr) &&
                (entry_ff.dst_port == tok_up.req.entry_dst_port) &&
                (entry_ff.service_id == tok_up.req.entry_service_id);
      slot_sel = {{(SLOT_CMP_W - 6){1'b0}}, tok_up.req.index} == SLOT_CMP_W'(CELL_IDX);
   end

   always_comb begin
      tok_in   = tok_up;
      entry_in = entry_ff;
      if (tok_up.valid) begin
         case (tok_up.req.operation)
            OP_LOOKUP: begin
               if (!tok_up.done && (entry_ff.remap_addr != 32'd0) && addr_ok && port_ok) begin
                  tok_in.done               = 1'b1;
                  tok_in.res.out_addr       = entry_ff.remap_addr;
                  tok_in.res.out_port       = (entry_ff.dst_port != 16'd0) ?
                                              entry_ff.dst_port : tok_up.req.port;
                  tok_in.res.out_service_id = entry_ff.service_id;
                  tok_in.res.hit            = 1'b1;
                  tok_in.res.entry_index    = 5'(CELL_IDX);
                  tok_in.res.status         = ST_OK;
               end
            end
            OP_ADD: begin
               // take the first free slot down the row
               if (!tok_up.done && (entry_ff.remap_addr == 32'd0)) begin
                  entry_in.match_addr    = tok_up.req.addr;
                  entry_in.mask          = tok_up.req.entry_mask;
                  entry_in.src_port      = tok_up.req.port;
                  entry_in.remap_addr    = tok_up.req.entry_remap_addr;
                  entry_in.dst_port      = tok_up.req.entry_dst_port;
                  entry_in.service_id    = tok_up.req.entry_service_id;
                  tok_in.done            = 1'b1;
                  tok_in.res.entry_index = 5'(CELL_IDX);
                  tok_in.res.status      = ST_OK;
               end
            end
            OP_DEL_MATCH: begin
               if (!tok_up.done && all_eq) begin
                  entry_in               = '0;
                  tok_in.done            = 1'b1;
                  tok_in.res.entry_index = 5'(CELL_IDX);
                  tok_in.res.status      = ST_OK;
               end
            end
            OP_DEL_INDEX: begin
               if (slot_sel) begin
                  entry_in               = '0;
                  tok_in.done            = 1'b1;
                  tok_in.res.entry_index = 5'(CELL_IDX);
                  tok_in.res.status      = ST_OK;
               end
            end
            OP_CLEAR: begin
               entry_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         entry_ff <= '0;
      end else if (advance) begin
         tok_ff   <= tok_in;
         entry_ff <= entry_in;
      end
   end

   assign tok_down = tok_ff;

endmodule

// ----- hw/rtl/masked_address_remap_table.sv -----
// Each cell holds one entry and a registered copy of the request, which it passes on to the
// next cell; the last cell's register drives rsp_tvalid.
// Throughput: one request per cycle unless the response stalls; requests stay in order
// through the row of cells. A stalled response holds the whole row in place.
// Reset: synchronous, active high; clears every entry (all slots free) and empties the row.
module masked_address_remap_table #(
   parameter int TABLE_ENTRIES = mart_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // addr[31:0] port[47:32] entry_mask[79:48] entry_remap_addr[111:80]
   // entry_dst_port[127:112] entry_service_id[159:128] index[165:160], zero fill
   input  logic [mart_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation[2:0]
   input  logic [mart_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_addr[31:0] out_port[47:32] out_service_id[79:48] hit[80]
   // entry_index[85:81] status[87:86]
   output logic [mart_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mart_pkg::*;

   token_type chain [TABLE_ENTRIES+1];
   token_type head;
   result_type last_res;
   logic advance;

   // the last cell's register is the response register
   assign advance    = !chain[TABLE_ENTRIES].valid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      head                      = '0;
      head.valid                = req_tvalid;
      head.req.operation        = req_tuser[2:0];
      head.req.addr             = req_tdata[31:0];
      head.req.port             = req_tdata[47:32];
      head.req.entry_mask       = req_tdata[79:48];
      head.req.entry_remap_addr = req_tdata[111:80];
      head.req.entry_dst_port   = req_tdata[127:112];
      head.req.entry_service_id = req_tdata[159:128];
      head.req.index            = req_tdata[165:160];
      // default answer when no cell claims the request
      case (req_tuser[2:0])
         OP_LOOKUP: begin
            head.res.out_addr = req_tdata[31:0];
            head.res.out_port = req_tdata[47:32];
            head.res.status   = ST_NOTFOUND;
         end
         OP_ADD:   head.res.status = ST_FULL;
         OP_CLEAR: head.res.status = ST_OK;
         default:  head.res.status = ST_NOTFOUND;
      endcase
   end

   assign chain[0] = head;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mart_cell #(
         .CELL_IDX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_up  (chain[g]),
         .tok_down(chain[g+1])
      );
   end

   assign last_res   = chain[TABLE_ENTRIES].res;
   assign rsp_tvalid = chain[TABLE_ENTRIES].valid;
   assign rsp_tdata  = {last_res.status, last_res.entry_index, last_res.hit,
                        last_res.out_service_id, last_res.out_port, last_res.out_addr};

endmodule

// ----- hw/rtl/mart_checker.sv -----
module mart_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mart_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mart_pkg::*;

   // a stalled response must not change under the consumer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // a hit always reports success
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[80] |-> rsp_tdata[87:86] == ST_OK)
      else $error("hit without ok status");

   // a full table reports no slot and no hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[87:86] == ST_FULL |-> rsp_tdata[85:80] == 6'd0)
      else $error("table full with slot or hit set");

   // the request side is held back while a response is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

endmodule

bind masked_address_remap_table mart_checker u_mart_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// ----- tb/masked_address_remap_table_test.sv -----
`timescale 1ns / 1ps

module masked_address_remap_table_test;
   import mart_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int IDLE_PCT = 37;
   localparam int HALF_RUN = 550;
   localparam int SEGMENT_LEN = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int MOOD_FILL = 0;
   localparam int MOOD_DRAIN = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic hold_rsp = 1'b0;
   int cycle_cnt = 0;
   int accepted_cnt = 0;
   int returned_cnt = 0;
   int error_cnt = 0;

   request_type pending_q[$];
   request_type offered_req;
   result_type expected_rsp_q[$];
   entry_type remap_tbl [TABLE_ENTRIES] = '{default: '0};
   entry_type added_hist[$];

   masked_address_remap_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one request to the table copy and work out its response.
   task automatic predict_remap(input request_type r, output result_type res);
      entry_type cand;
      cand = '{r.addr, r.entry_mask, r.port, r.entry_remap_addr, r.entry_dst_port,
               r.entry_service_id};
      res = '0;
      res.status = ST_NOTFOUND;
      case (r.operation)
         OP_LOOKUP: begin
            res.out_addr = r.addr;
            res.out_port = r.port;
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
               if (remap_tbl[s].remap_addr != '0 &&
                   remap_tbl[s].match_addr == (r.addr & remap_tbl[s].mask) &&
                   (remap_tbl[s].src_port == '0 || r.port == '0 ||
                    remap_tbl[s].src_port == r.port)) begin
                  res.out_addr = remap_tbl[s].remap_addr;
                  res.out_port = (remap_tbl[s].dst_port != '0) ? remap_tbl[s].dst_port : r.port;
                  res.out_service_id = remap_tbl[s].service_id;
                  res.hit = 1'b1;
                  res.entry_index = 5'(s);
                  res.status = ST_OK;
                  break;
               end
            end
         end
         OP_ADD: begin
            res.status = ST_FULL;
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
               if (remap_tbl[s].remap_addr == '0) begin
                  remap_tbl[s] = cand;
                  res.entry_index = 5'(s);
                  res.status = ST_OK;
                  break;
               end
            end
         end
         OP_DEL_MATCH: begin
            // slots freed by reset, clear or delete are all zero, so an all-zero request removes one of them
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
               if (remap_tbl[s] == cand) begin
                  remap_tbl[s] = '0;
                  res.entry_index = 5'(s);
                  res.status = ST_OK;
                  break;
               end
            end
         end
         OP_DEL_INDEX: begin
            if (int'(r.index) < TABLE_ENTRIES) begin
               remap_tbl[r.index] = '0;
               res.entry_index = 5'(r.index);
               res.status = ST_OK;
            end
         end
         OP_CLEAR: begin
            foreach (remap_tbl[s]) remap_tbl[s] = '0;
            res.status = ST_OK;
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(string msg);
      if (error_cnt < 100) $display("mismatch: %s", msg);
      error_cnt++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got %h want %h",
                                   returned_cnt, name, got, want));
   endtask

   // Hold until every queued request has gone in and every response has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [15:0] random_port();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'd80;
         3: return 16'd443;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic entry_type random_entry();
      entry_type e;
      int plen;
      plen = $urandom_range(32);
      case ($urandom_range(5))
         0: e.mask = '0;
         1: e.mask = '1;
         2: e.mask = $urandom;
         default: e.mask = 32'hFFFF_FFFF << (32 - plen);
      endcase
      // now and then a match address that no lookup can reach
      e.match_addr = ($urandom_range(9) == 0) ? $urandom : ($urandom & e.mask);
      e.src_port = random_port();
      case ($urandom_range(15))
         0: e.remap_addr = '0;
         1: e.remap_addr = '1;
         default: e.remap_addr = $urandom;
      endcase
      e.dst_port = random_port();
      e.service_id = $urandom;
      return e;
   endfunction

   function automatic request_type entry_request(logic [2:0] op, entry_type e, logic [5:0] idx);
      request_type r;
      r.operation = op;
      r.addr = e.match_addr;
      r.port = e.src_port;
      r.entry_mask = e.mask;
      r.entry_remap_addr = e.remap_addr;
      r.entry_dst_port = e.dst_port;
      r.entry_service_id = e.service_id;
      r.index = idx;
      return r;
   endfunction

   function automatic request_type next_table_request(int mood);
      request_type r;
      entry_type e;
      int roll, p_look, p_add, p_dm, p_di, p_clr;
      case (mood)
         MOOD_FILL: begin p_look = 30; p_add = 60; p_dm = 4; p_di = 4; p_clr = 0; end
         MOOD_DRAIN: begin p_look = 35; p_add = 10; p_dm = 25; p_di = 25; p_clr = 2; end
         default: begin p_look = 45; p_add = 25; p_dm = 12; p_di = 12; p_clr = 2; end
      endcase
      roll = $urandom_range(99);
      // unused fields carry random bits
      r = entry_request(OP_LOOKUP, random_entry(), 6'($urandom_range(63)));
      r.addr = $urandom;
      if (roll < p_look) begin
         if (added_hist.size() != 0 && $urandom_range(9) < 7) begin
            e = added_hist[$urandom_range(added_hist.size() - 1)];
            r.addr = e.match_addr | ($urandom & ~e.mask);
            case ($urandom_range(2))
               0: r.port = e.src_port;
               1: r.port = '0;
               default: r.port = random_port();
            endcase
         end else begin
            case ($urandom_range(3))
               0: r.addr = '0;
               1: r.addr = '1;
               default: r.addr = $urandom;
            endcase
            r.port = random_port();
         end
      end else if (roll < p_look + p_add) begin
         e = random_entry();
         r = entry_request(OP_ADD, e, 6'($urandom_range(63)));
         added_hist.push_back(e);
         if (added_hist.size() > 48) void'(added_hist.pop_front());
      end else if (roll < p_look + p_add + p_dm) begin
         if (added_hist.size() != 0 && $urandom_range(9) < 6)
            e = added_hist[$urandom_range(added_hist.size() - 1)];
         else if ($urandom_range(2) == 0)
            e = '0;
         else
            e = random_entry();
         r = entry_request(OP_DEL_MATCH, e, 6'($urandom_range(63)));
      end else if (roll < p_look + p_add + p_dm + p_di) begin
         r.operation = OP_DEL_INDEX;
         r.index = $urandom_range(1) ? 6'($urandom_range(TABLE_ENTRIES - 1))
                                      : 6'($urandom_range(63));
      end else if (roll < p_look + p_add + p_dm + p_di + p_clr) begin
         r.operation = OP_CLEAR;
      end else begin
         r.operation = 3'(OP_CLEAR + $urandom_range(1, 3));
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_remap(offered_req, want);
            expected_rsp_q.push_back(want);
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 &&
                ((accepted_cnt >= 500 && accepted_cnt < 700) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               offered_req = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, offered_req.index, offered_req.entry_service_id,
                             offered_req.entry_dst_port, offered_req.entry_remap_addr,
                             offered_req.entry_mask, offered_req.port, offered_req.addr};
               req_tuser <= offered_req.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_addr = rsp_tdata[31:0];
            got.out_port = rsp_tdata[47:32];
            got.out_service_id = rsp_tdata[79:48];
            got.hit = rsp_tdata[80];
            got.entry_index = rsp_tdata[85:81];
            got.status = rsp_tdata[87:86];
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding, addr %h",
                                         returned_cnt, got.out_addr));
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("out_addr", got.out_addr, want.out_addr);
               check_field("out_port", got.out_port, want.out_port);
               check_field("out_service_id", got.out_service_id, want.out_service_id);
               check_field("hit", got.hit, want.hit);
               check_field("entry_index", got.entry_index, want.entry_index);
               check_field("status", got.status, want.status);
            end
            returned_cnt++;
         end
         rsp_tready <= !hold_rsp && ((returned_cnt >= 500 && returned_cnt < 700) ||
                                     $urandom_range(99) >= IDLE_PCT);
      end
   end

   // long back-pressure so the row fills and the request side stalls
   initial begin
      @(negedge clock);
      while (accepted_cnt < 250) @(negedge clock);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      entry_type ent_a;
      entry_type ent_b;
      entry_type ent_c;
      entry_type ent_free;
      entry_type ent_z;
      ent_a = '{32'h0A00_0000, 32'hFF00_0000, 16'd80, 32'hC0A8_0001, 16'd0, 32'hFFFF_FFFF};
      ent_b = '{32'h0, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 32'h1};
      ent_c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h1, 16'h1234, 32'h0};
      ent_free = '{32'h1234_5678, 32'hFFFF_0000, 16'd7, 32'h0, 16'd9, 32'd5};
      ent_z = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table: misses at the extremes
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, ent_z, 6'd0));
      // delete by index on a free slot, then out of range
      pending_q.push_back(entry_request(OP_DEL_INDEX, ent_z, 6'd0));
      pending_q.push_back(entry_request(OP_DEL_INDEX, ent_z, 6'd32));
      pending_q.push_back(entry_request(OP_DEL_INDEX, ent_z, 6'd63));
      // an all-zero match hits a free slot; a real entry is not there yet
      pending_q.push_back(entry_request(OP_DEL_MATCH, ent_z, 6'd0));
      pending_q.push_back(entry_request(OP_DEL_MATCH, ent_a, 6'd0));
      pending_q.push_back(entry_request(OP_ADD, ent_a, 6'd0));
      pending_q.push_back(entry_request(OP_ADD, ent_b, 6'd0));
      // zero remap address: slot written but left free
      pending_q.push_back(entry_request(OP_ADD, ent_free, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'h0A12_3456, 0, 16'd80, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'h0A12_3456, 0, 16'd0, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'h0A12_3456, 0, 16'd81, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_ADD, ent_c, 6'd0));
      pending_q.push_back(entry_request(OP_DEL_MATCH, ent_a, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_DEL_INDEX, ent_z, 6'd1));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0, 0}, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 16'd1, 0, 0, 0}, 6'd0));
      for (int k = 1; k <= 3; k++)
         pending_q.push_back(entry_request(3'(OP_CLEAR + k), ent_c, 6'd0));
      pending_q.push_back(entry_request(OP_CLEAR, ent_z, 6'd0));
      pending_q.push_back(entry_request(OP_LOOKUP, '{32'hFFFF_FFFF, 0, 16'd0, 0, 0, 0}, 6'd0));
      wait_drained();

      for (int n = 0; n < HALF_RUN; n++)
         pending_q.push_back(next_table_request((n / SEGMENT_LEN) % 3));
      // sender pauses here until every response is back
      wait_drained();
      for (int n = 0; n < HALF_RUN; n++)
         pending_q.push_back(next_table_request((n / SEGMENT_LEN + 1) % 3));
      wait_drained();
      repeat (2 * TABLE_ENTRIES) @(posedge clock);

      if (error_cnt == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mart_pkg.sv
hw/rtl/mart_cell.sv
hw/rtl/masked_address_remap_table.sv
hw/rtl/mart_checker.sv
tb/masked_address_remap_table_test.sv
